/* rtl/core/abu_pkg.sv */
package abu_pkg;

	// counter and deadline width
	localparam int CNT_W = 24;
	// bit period is one eighth of the eight-bit measurement
	localparam int PER_W = CNT_W - 3;

	localparam int IN_FIELDS_W  = 10;
	localparam int IN_W         = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 12 + CNT_W;
	localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [PER_W-1:0] per_t;

	localparam cnt_t CNT_MAX = '1;

	typedef enum logic [2:0] {
		TRN_WAIT_LOW,
		TRN_WAIT_RISE,
		TRN_CNT_LOW,
		TRN_CNT_RISE,
		TRN_LOCKED
	} train_phase_t;

	typedef enum logic [1:0] {
		RX_WAIT_HIGH,
		RX_WAIT_START,
		RX_DATA
	} rx_phase_t;

	// trainer status as seen at the start of a tick
	typedef struct packed {
		logic locked;
		per_t bit_period;
	} baud_t;

	// result word, tx_line in bit 0
	typedef struct packed {
		cnt_t       eight_bit_cycles;
		logic       locked;
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic       tx_busy;
		logic       tx_line;
	} result_t;

	function automatic cnt_t sat_add(input cnt_t a, input cnt_t b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

endpackage

/* rtl/core/autobaud_uart_top.sv */
// Each result is registered before the master side sees it; a stalled master side holds it back.
// Throughput: one input transaction per cycle; the two-entry output buffer keeps
// s_axis_tready high while one finished result waits, so only a stall of two
// results holds the input side.
// Reset: arst_n low clears trainer, receiver, transmitter and the output buffer at once.
module autobaud_uart_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// rx_line[0], tx_start[1], tx_byte[9:2], zero pad above
	input  logic [abu_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// tx_line[0], tx_busy[1], rx_valid[2], rx_byte[10:3], locked[11],
	// eight_bit_cycles[35:12], zero pad above
	output logic [abu_pkg::OUT_W-1:0] m_axis_tdata
);

	// Each input transaction is one sampling tick of the serial line. Trainer, receiver
	// and transmitter state advance only on an accepted transaction, so a stall simply freezes time.
	logic            step;
	logic            rx_line;
	logic            tx_start;
	logic [7:0]      tx_byte;

	abu_pkg::baud_t  baud;
	logic            locked_nx;
	abu_pkg::cnt_t   measured_nx;
	logic            rx_valid;
	logic [7:0]      rx_byte;
	logic            tx_line;
	logic            tx_busy;
	abu_pkg::result_t result;

	assign step     = s_axis_tvalid && s_axis_tready;
	assign rx_line  = s_axis_tdata[0];
	assign tx_start = s_axis_tdata[1];
	assign tx_byte  = s_axis_tdata[9:2];

	// Trainer: measures first-rise to second-rise of a '?' character, which
	// spans eight bit times; the bit period is that count over eight.
	abu_train u_train (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.line        (rx_line),
		.baud        (baud),
		.locked_nx   (locked_nx),
		.measured_nx (measured_nx)
	);

	// Receiver: runs only once locked (status from the start of the tick),
	// samples mid-bit at 1.5, 2.5 .. 8.5 periods after the start edge.
	abu_rx u_rx (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.line   (rx_line),
		.baud   (baud),
		.valid  (rx_valid),
		.data   (rx_byte)
	);

	// Transmitter: start, 8 data bits and stop on cumulative period deadlines.
	abu_tx u_tx (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.start  (tx_start),
		.data   (tx_byte),
		.baud   (baud),
		.line   (tx_line),
		.busy   (tx_busy)
	);

	assign result.tx_line          = tx_line;
	assign result.tx_busy          = tx_busy;
	assign result.rx_valid         = rx_valid;
	assign result.rx_byte          = rx_byte;
	assign result.locked           = locked_nx;
	assign result.eight_bit_cycles = measured_nx;

	// Result register plus skid entry between the tick logic and the master side.
	abu_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (abu_pkg::OUT_W'(result)),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

/* rtl/core/abu_train.sv */
module abu_train (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic           line,
	output abu_pkg::baud_t baud,
	output logic           locked_nx,
	output abu_pkg::cnt_t  measured_nx
);

	abu_pkg::train_phase_t phase_q, phase_d;
	abu_pkg::cnt_t         count_q, count_d;
	abu_pkg::cnt_t         measured_q;
	abu_pkg::per_t         period_q;

	always_comb begin
		phase_d     = phase_q;
		count_d     = count_q;
		measured_nx = measured_q;
		unique case (phase_q)
			abu_pkg::TRN_WAIT_LOW: begin
				if (!line) phase_d = abu_pkg::TRN_WAIT_RISE;
			end
			abu_pkg::TRN_WAIT_RISE: begin
				if (line) begin
					count_d = '0;
					phase_d = abu_pkg::TRN_CNT_LOW;
				end
			end
			abu_pkg::TRN_CNT_LOW: begin
				count_d = abu_pkg::sat_add(count_q, abu_pkg::cnt_t'(1));
				if (!line) phase_d = abu_pkg::TRN_CNT_RISE;
			end
			abu_pkg::TRN_CNT_RISE: begin
				count_d = abu_pkg::sat_add(count_q, abu_pkg::cnt_t'(1));
				if (line) begin
					measured_nx = count_d;
					phase_d     = abu_pkg::TRN_LOCKED;
				end
			end
			default: begin
			end
		endcase
		locked_nx = (phase_d == abu_pkg::TRN_LOCKED);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= abu_pkg::TRN_WAIT_LOW;
			count_q    <= '0;
			measured_q <= '0;
			period_q   <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			count_q    <= count_d;
			measured_q <= measured_nx;
			period_q   <= measured_nx[abu_pkg::CNT_W-1:3];
		end
	end

	assign baud.locked     = (phase_q == abu_pkg::TRN_LOCKED);
	assign baud.bit_period = period_q;

endmodule

/* rtl/core/abu_rx.sv */
module abu_rx (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic           line,
	input  abu_pkg::baud_t baud,
	output logic           valid,
	output logic [7:0]     data
);

	abu_pkg::rx_phase_t phase_q, phase_d;
	abu_pkg::cnt_t      count_q, count_d;
	abu_pkg::cnt_t      deadline_q, deadline_d;
	logic [7:0]         shift_q, shift_d;
	logic [3:0]         bits_q, bits_d;
	abu_pkg::cnt_t      per;

	assign per = abu_pkg::cnt_t'(baud.bit_period);

	always_comb begin
		phase_d    = phase_q;
		count_d    = count_q;
		deadline_d = deadline_q;
		shift_d    = shift_q;
		bits_d     = bits_q;
		valid      = 1'b0;
		data       = '0;
		if (baud.locked) begin
			unique case (phase_q)
				abu_pkg::RX_WAIT_HIGH: begin
					if (line) phase_d = abu_pkg::RX_WAIT_START;
				end
				abu_pkg::RX_WAIT_START: begin
					if (!line) begin
						// first sample one and a half periods after the edge
						count_d    = '0;
						deadline_d = abu_pkg::sat_add(per >> 1, per);
						shift_d    = '0;
						bits_d     = '0;
						phase_d    = abu_pkg::RX_DATA;
					end
				end
				abu_pkg::RX_DATA: begin
					count_d = abu_pkg::sat_add(count_q, abu_pkg::cnt_t'(1));
					if (count_d >= deadline_q) begin
						if (line) shift_d[bits_q[2:0]] = 1'b1;
						bits_d     = bits_q + 4'd1;
						deadline_d = abu_pkg::sat_add(deadline_q, per);
						if (bits_d >= 4'd8) begin
							valid   = 1'b1;
							data    = shift_d;
							bits_d  = '0;
							phase_d = abu_pkg::RX_WAIT_HIGH;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= abu_pkg::RX_WAIT_HIGH;
			count_q    <= '0;
			deadline_q <= '0;
			shift_q    <= '0;
			bits_q     <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			count_q    <= count_d;
			deadline_q <= deadline_d;
			shift_q    <= shift_d;
			bits_q     <= bits_d;
		end
	end

endmodule

/* rtl/core/abu_tx.sv */
module abu_tx (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic           start,
	input  logic [7:0]     data,
	input  abu_pkg::baud_t baud,
	output logic           line,
	output logic           busy
);

	logic [9:0]    shift_q, shift_d;
	abu_pkg::cnt_t count_q, count_d;
	abu_pkg::cnt_t deadline_q, deadline_d;
	abu_pkg::cnt_t per;

	assign per = abu_pkg::cnt_t'(baud.bit_period);

	always_comb begin
		shift_d    = shift_q;
		count_d    = count_q;
		deadline_d = deadline_q;
		if (shift_q != '0) begin
			count_d = abu_pkg::sat_add(count_q, abu_pkg::cnt_t'(1));
			if (count_d >= deadline_q) begin
				shift_d    = shift_q >> 1;
				deadline_d = abu_pkg::sat_add(deadline_q, per);
			end
		end else if (start && baud.locked) begin
			// stop, data LSB first, start
			shift_d    = {1'b1, data, 1'b0};
			count_d    = '0;
			deadline_d = per;
		end
		busy = (shift_d != '0);
		line = busy ? shift_d[0] : 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q    <= '0;
			count_q    <= '0;
			deadline_q <= '0;
		end else if (step) begin
			shift_q    <= shift_d;
			count_q    <= count_d;
			deadline_q <= deadline_d;
		end
	end

endmodule

/* rtl/core/abu_skid.sv */
module abu_skid (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [abu_pkg::OUT_W-1:0] in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [abu_pkg::OUT_W-1:0] out_data
);

	logic                      out_valid_q;
	logic [abu_pkg::OUT_W-1:0] out_data_q;
	logic                      skid_valid_q;
	logic [abu_pkg::OUT_W-1:0] skid_data_q;
	logic                      push;
	logic                      free;

	assign in_ready  = !skid_valid_q;
	assign push      = in_valid && in_ready;
	assign free      = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= push;
			end else begin
				out_valid_q  <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (free) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
				if (push) skid_data_q <= in_data;
			end else if (push) begin
				out_data_q <= in_data;
			end
		end else if (push) begin
			skid_data_q <= in_data;
		end
	end

endmodule

/* rtl/core/abu_checker.sv */
module abu_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tvalid,
	input logic                      s_axis_tready,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [abu_pkg::OUT_W-1:0] m_axis_tdata
);

	// every accepted tick shows a result the next cycle
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted tick produced no result");

	// a pending result is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// received byte field is zero unless a byte completes
	a_rx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[10:3] == 8'd0)
		else $error("rx_byte nonzero without rx_valid");

	// idle transmitter holds the line high
	a_tx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[0])
		else $error("tx line low while idle");

	// before lock: no measurement, no transmit, no receive
	a_unlocked: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[11] |->
			m_axis_tdata[35:12] == 24'd0 && !m_axis_tdata[1] && !m_axis_tdata[2])
		else $error("activity before lock");

endmodule

bind autobaud_uart_top abu_checker u_abu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
